FILE: hdl/ccfd_pkg.sv
// Package for the CRC-checked frame deframer: phase type, status codes,
// framing constants and the byte-wide CRC-8 / CRC-16 update functions.
// No dependencies.
package ccfd_pkg;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_HEAD  = 6'b000010,
        PH_CMD   = 6'b000100,
        PH_PAY   = 6'b001000,
        PH_CRCLO = 6'b010000,
        PH_CRCHI = 6'b100000
    } phase_t;

    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_GOOD    = 3'd1;
    localparam logic [2:0] ST_BAD16   = 3'd2;
    localparam logic [2:0] ST_BAD8    = 3'd3;
    localparam logic [2:0] ST_TOOLONG = 3'd4;

    localparam logic [7:0]  SOF_BYTE        = 8'hA5;
    localparam logic [7:0]  CRC8_SEED       = 8'hFF;
    localparam logic [15:0] CRC16_SEED      = 16'hFFFF;
    localparam logic [7:0]  CRC8_POLY_REV   = 8'h8C;
    localparam logic [15:0] CRC16_POLY_REV  = 16'h8408;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd512;
    localparam logic [15:0] HEADER_CRC_POS  = 16'd4;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY_REV) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY_REV) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/crc_checked_frame_deframer.sv
// Top level of the CRC-checked frame deframer: byte input register, framing
// state machine with CRC-8/CRC-16 update, and the result register.
// Depends on ccfd_pkg.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | s_tdata: rx_byte
//  m_*      | out | m_tvalid/m_tready | m_tuser: status; m_tdata: command_id,
//           |     |                   |   sequence_res, payload_byte, payload_index
//  cfg_*    | in  | cfg_we            | cfg_wdata: max_payload_len
//
// One byte per cycle sustained while the output is not stalled: a byte is
// held in the input register, then the state machine and both CRC registers
// update and any result loads into the output register.
// rst_n clears the state to hunting and the length limit to 512.
// A stalled output holds its transaction; the input register keeps taking
// bytes while the output is free or being drained in the same cycle.
module crc_checked_frame_deframer
    import ccfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,     // [2:0] status
    output logic [47:0] m_tdata,     // [15:0] command_id, [23:16] sequence_res,
                                     // [31:24] payload_byte, [47:32] payload_index
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    phase_t      phase_reg,       phase_next;
    logic [15:0] byte_count_reg,  byte_count_next;
    logic [15:0] length_reg,      length_next;
    logic [7:0]  crc8_reg,        crc8_next;
    logic [15:0] crc16_reg,       crc16_next;
    logic [15:0] command_reg,     command_next;
    logic [7:0]  sequence_reg,    sequence_next;
    logic [7:0]  crc_low_reg,     crc_low_next;
    logic [15:0] max_len_reg;

    logic [7:0]  crc8_upd;
    logic [15:0] crc16_upd;
    logic [15:0] count_inc;

    logic        res_valid;
    logic [2:0]  res_status;
    logic [15:0] res_command;
    logic [7:0]  res_byte;
    logic [15:0] res_index;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [47:0] out_data_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign crc8_upd  = crc8_byte(crc8_reg, in_byte_reg);
    assign crc16_upd = crc16_byte(crc16_reg, in_byte_reg);
    assign count_inc = byte_count_reg + 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        length_next     = length_reg;
        crc8_next       = crc8_reg;
        crc16_next      = crc16_reg;
        command_next    = command_reg;
        sequence_next   = sequence_reg;
        crc_low_next    = crc_low_reg;
        res_valid       = 1'b0;
        res_status      = ST_PAYLOAD;
        res_command     = 16'h0000;
        res_byte        = 8'h00;
        res_index       = length_reg;
        unique case (phase_reg)
            PH_HEAD:
            begin
                if (byte_count_reg < HEADER_CRC_POS)
                begin
                    if (byte_count_reg == 16'd1)
                    begin
                        length_next = {8'h00, in_byte_reg};
                    end
                    else if (byte_count_reg == 16'd2)
                    begin
                        length_next = {in_byte_reg, length_reg[7:0]};
                    end
                    else
                    begin
                        sequence_next = in_byte_reg;
                    end
                    crc8_next       = crc8_upd;
                    crc16_next      = crc16_upd;
                    byte_count_next = count_inc;
                end
                else
                begin
                    phase_next      = PH_HUNT;
                    byte_count_next = 16'h0000;
                    if (in_byte_reg != crc8_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_BAD8;
                    end
                    else if (length_reg > max_len_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TOOLONG;
                    end
                    else
                    begin
                        crc16_next = crc16_upd;
                        phase_next = PH_CMD;
                    end
                end
            end
            PH_CMD:
            begin
                crc16_next = crc16_upd;
                if (byte_count_reg == 16'h0000)
                begin
                    command_next    = {8'h00, in_byte_reg};
                    byte_count_next = 16'd1;
                end
                else
                begin
                    command_next    = {in_byte_reg, command_reg[7:0]};
                    byte_count_next = 16'h0000;
                    phase_next      = (length_reg == 16'h0000) ? PH_CRCLO : PH_PAY;
                end
            end
            PH_PAY:
            begin
                crc16_next = crc16_upd;
                if (count_inc >= length_reg)
                begin
                    byte_count_next = 16'h0000;
                    phase_next      = PH_CRCLO;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
                res_valid   = 1'b1;
                res_status  = ST_PAYLOAD;
                res_command = command_reg;
                res_byte    = in_byte_reg;
                res_index   = byte_count_reg;
            end
            PH_CRCLO:
            begin
                crc_low_next = in_byte_reg;
                phase_next   = PH_CRCHI;
            end
            PH_CRCHI:
            begin
                phase_next      = PH_HUNT;
                byte_count_next = 16'h0000;
                res_valid       = 1'b1;
                res_command     = command_reg;
                if (crc_low_reg == crc16_reg[7:0] && in_byte_reg == crc16_reg[15:8])
                begin
                    res_status = ST_GOOD;
                end
                else
                begin
                    res_status = ST_BAD16;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (in_byte_reg == SOF_BYTE)
                begin
                    crc8_next       = crc8_byte(CRC8_SEED, in_byte_reg);
                    crc16_next      = crc16_byte(CRC16_SEED, in_byte_reg);
                    byte_count_next = 16'd1;
                    length_next     = 16'h0000;
                    command_next    = 16'h0000;
                    phase_next      = PH_HEAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_HUNT;
            byte_count_reg <= 16'h0000;
            length_reg     <= 16'h0000;
            crc8_reg       <= CRC8_SEED;
            crc16_reg      <= CRC16_SEED;
            command_reg    <= 16'h0000;
            sequence_reg   <= 8'h00;
            crc_low_reg    <= 8'h00;
            max_len_reg    <= MAX_LEN_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                length_reg     <= length_next;
                crc8_reg       <= crc8_next;
                crc16_reg      <= crc16_next;
                command_reg    <= command_next;
                sequence_reg   <= sequence_next;
                crc_low_reg    <= crc_low_next;
            end
            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the byte and the result payloads
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= {res_index, res_byte, sequence_reg, res_command};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: tb/crc_checked_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for crc_checked_frame_deframer: builds framed byte streams,
// predicts every result with its own deframer model and checks the output stream.
// Depends on ccfd_pkg and the deframer RTL.
module crc_checked_frame_deframer_tb;
    import ccfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BYTES = 20;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_HDR_CRC_BAD,
        FRAME_CRC_LO_BAD,
        FRAME_CRC_HI_BAD,
        FRAME_BODY_FLIP
    } frame_fault_t;

    typedef enum int {
        RX_STREAM,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] cmd;
        logic [7:0]  seq;
        logic [7:0]  pbyte;
        logic [15:0] pidx;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    frame_result_t pending_results[$];
    int            mismatches = 0;
    int            bytes_sent = 0;
    int            burst_left = 0;
    int            hold_request = 0;

    logic [15:0] len_limit = MAX_LEN_RESET;
    phase_t      rx_phase = PH_HUNT;
    logic [15:0] byte_pos = 16'h0000;
    logic [15:0] frame_len = 16'h0000;
    logic [7:0]  hdr_crc = CRC8_SEED;
    logic [15:0] frame_crc = CRC16_SEED;
    logic [15:0] frame_cmd = 16'h0000;
    logic [7:0]  frame_seq = 8'h00;
    logic [7:0]  crc_low_byte = 8'h00;

    crc_checked_frame_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ data[i])
                c = (c >> 1) ^ CRC8_POLY_REV;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ data[i])
                c = (c >> 1) ^ CRC16_POLY_REV;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        frame_result_t r;
        bit            hit;
        r = '0;
        hit = 1'b0;
        case (rx_phase)
            PH_HEAD:
            begin
                if (byte_pos < HEADER_CRC_POS)
                begin
                    if (byte_pos == 16'd1)
                        frame_len = {8'h00, b};
                    else if (byte_pos == 16'd2)
                        frame_len = {b, frame_len[7:0]};
                    else
                        frame_seq = b;
                    hdr_crc = crc8_step(hdr_crc, b);
                    frame_crc = crc16_step(frame_crc, b);
                    byte_pos = byte_pos + 16'd1;
                end
                else
                begin
                    rx_phase = PH_HUNT;
                    byte_pos = 16'h0000;
                    if (b != hdr_crc)
                    begin
                        hit = 1'b1;
                        r.status = ST_BAD8;
                        r.pidx = frame_len;
                    end
                    else if (frame_len > len_limit)
                    begin
                        hit = 1'b1;
                        r.status = ST_TOOLONG;
                        r.pidx = frame_len;
                    end
                    else
                    begin
                        frame_crc = crc16_step(frame_crc, b);
                        rx_phase = PH_CMD;
                    end
                end
            end
            PH_CMD:
            begin
                frame_crc = crc16_step(frame_crc, b);
                if (byte_pos == 16'h0000)
                begin
                    frame_cmd = {8'h00, b};
                    byte_pos = 16'd1;
                end
                else
                begin
                    frame_cmd = {b, frame_cmd[7:0]};
                    byte_pos = 16'h0000;
                    rx_phase = (frame_len == 16'h0000) ? PH_CRCLO : PH_PAY;
                end
            end
            PH_PAY:
            begin
                frame_crc = crc16_step(frame_crc, b);
                hit = 1'b1;
                r.status = ST_PAYLOAD;
                r.cmd = frame_cmd;
                r.pbyte = b;
                r.pidx = byte_pos;
                byte_pos = byte_pos + 16'd1;
                if (byte_pos >= frame_len)
                begin
                    byte_pos = 16'h0000;
                    rx_phase = PH_CRCLO;
                end
            end
            PH_CRCLO:
            begin
                crc_low_byte = b;
                rx_phase = PH_CRCHI;
            end
            PH_CRCHI:
            begin
                rx_phase = PH_HUNT;
                byte_pos = 16'h0000;
                hit = 1'b1;
                r.cmd = frame_cmd;
                r.pidx = frame_len;
                if (crc_low_byte == frame_crc[7:0] && b == frame_crc[15:8])
                    r.status = ST_GOOD;
                else
                    r.status = ST_BAD16;
            end
            default:
            begin
                rx_phase = PH_HUNT;
                if (b == SOF_BYTE)
                begin
                    hdr_crc = crc8_step(CRC8_SEED, b);
                    frame_crc = crc16_step(CRC16_SEED, b);
                    byte_pos = 16'd1;
                    frame_len = 16'h0000;
                    frame_cmd = 16'h0000;
                    rx_phase = PH_HEAD;
                end
            end
        endcase
        if (hit)
        begin
            r.seq = frame_seq;
            pending_results.push_back(r);
        end
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, tdata 0x%h", m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 16'(want.status), 16'(m_tuser));
                compare_field("command_id", want.cmd, m_tdata[15:0]);
                compare_field("sequence_res", 16'(want.seq), 16'(m_tdata[23:16]));
                compare_field("payload_byte", 16'(want.pbyte), 16'(m_tdata[31:24]));
                compare_field("payload_index", want.pidx, m_tdata[47:32]);
            end
        end
    end

    initial
    begin : receiver
        int       hold_left;
        int       mode_left;
        int       tick;
        rx_mode_t mode;
        logic     ready_next;
        hold_left = 0;
        mode_left = 0;
        tick = 0;
        mode = RX_STREAM;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(RX_STREAM, RX_PERIODIC));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (mode)
                    RX_STREAM:  ready_next = 1'b1;
                    RX_LIGHT:   ready_next = ($urandom_range(0, 3) != 0);
                    RX_HEAVY:   ready_next = ($urandom_range(0, 3) == 0);
                    default:    ready_next = ((tick % 4) != 3);
                endcase
            end
            m_tready <= ready_next;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            repeat ($urandom_range(0, 5))
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] len, input logic [15:0] cmd,
                              input logic [7:0] seq, input frame_fault_t fault);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  h8;
        logic [15:0] f16;
        logic [7:0]  mask;
        int          pos;
        frame_bytes = {SOF_BYTE, len[7:0], len[15:8], seq};
        h8 = CRC8_SEED;
        foreach (frame_bytes[i])
            h8 = crc8_step(h8, frame_bytes[i]);
        frame_bytes.push_back((fault == FRAME_HDR_CRC_BAD) ? ~h8 : h8);
        if (fault != FRAME_HDR_CRC_BAD && len <= len_limit)
        begin
            frame_bytes.push_back(cmd[7:0]);
            frame_bytes.push_back(cmd[15:8]);
            repeat (len)
                frame_bytes.push_back(8'($urandom));
            f16 = CRC16_SEED;
            foreach (frame_bytes[i])
                f16 = crc16_step(f16, frame_bytes[i]);
            frame_bytes.push_back(f16[7:0]);
            frame_bytes.push_back(f16[15:8]);
            mask = 8'h01 << $urandom_range(0, 7);
            pos = frame_bytes.size() - 1;
            case (fault)
                FRAME_CRC_LO_BAD: pos = pos - 1;
                FRAME_CRC_HI_BAD: pos = pos;
                FRAME_BODY_FLIP:  pos = $urandom_range(5, frame_bytes.size() - 3);
                default:          mask = 8'h00;
            endcase
            frame_bytes[pos] = frame_bytes[pos] ^ mask;
        end
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    task automatic drain_results(input int settle);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain_results(4);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        len_limit = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_clean_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'd0, 16'h0000, 8'h00, FRAME_CLEAN);
        send_frame(16'd1, 16'hFFFF, 8'hFF, FRAME_CLEAN);
    endtask

    task automatic test_header_errors();
        send_frame(16'd3, 16'h1234, SOF_BYTE, FRAME_HDR_CRC_BAD);
        send_frame(16'hFFFF, 16'h0000, 8'h5A, FRAME_CLEAN);
        send_frame(16'd2, 16'hA55A, 8'h01, FRAME_CLEAN);
    endtask

    task automatic test_frame_crc_faults();
        send_frame(16'd1, 16'h00FF, 8'h10, FRAME_CRC_LO_BAD);
        send_frame(16'd0, 16'hFF00, 8'h11, FRAME_CRC_HI_BAD);
        send_frame(16'd2, 16'h8001, 8'h12, FRAME_BODY_FLIP);
    endtask

    task automatic test_length_limit();
        write_limit(16'd6);
        send_frame(16'd6, 16'h0102, 8'h20, FRAME_CLEAN);
        send_frame(16'd7, 16'h0304, 8'h21, FRAME_CLEAN);
        write_limit(16'd0);
        send_frame(16'd0, 16'h0506, 8'h22, FRAME_CLEAN);
        send_frame(16'd1, 16'h0708, 8'h23, FRAME_CLEAN);
        write_limit(16'hFFFF);
        send_frame(16'd257, 16'h090A, 8'h24, FRAME_CLEAN);
        write_limit(MAX_LEN_RESET);
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        repeat (2)
            send_frame(16'd10, 16'($urandom), 8'($urandom), FRAME_CLEAN);
        drain_results(4);
    endtask

    task automatic test_random_traffic();
        int           target;
        int           pick;
        int           cap;
        logic [15:0]  len;
        frame_fault_t fault;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       write_limit(16'd12);
                1:       write_limit(16'd0);
                2:       write_limit(16'hFFFF);
                3:       write_limit(16'($urandom_range(1, 40)));
                4:       write_limit(16'd3);
                default: write_limit(MAX_LEN_RESET);
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                pick = $urandom_range(0, 99);
                cap = ($urandom_range(0, 9) == 0) ? 48 : 6;
                if (cap > int'(len_limit))
                    cap = int'(len_limit);
                len = 16'($urandom_range(0, cap));
                fault = FRAME_CLEAN;
                if (pick >= 65 && pick < 77)
                    fault = frame_fault_t'($urandom_range(FRAME_CRC_LO_BAD, FRAME_BODY_FLIP));
                else if (pick >= 77 && pick < 84)
                    fault = FRAME_HDR_CRC_BAD;
                else if (pick >= 84 && pick < 90 && len_limit != 16'hFFFF)
                    len = $urandom_range(0, 1) ? len_limit + 16'd1
                                               : 16'($urandom_range(len_limit + 1, 16'hFFFF));
                if (pick >= 90)
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom));
                else
                    send_frame(len, 16'($urandom), 8'($urandom), fault);
            end
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_clean_frames();
        test_header_errors();
        test_frame_crc_faults();
        test_length_limit();
        test_backpressure();
        test_random_traffic();
        drain_results(10);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hdl/ccfd_pkg.sv
hdl/crc_checked_frame_deframer.sv
tb/crc_checked_frame_deframer_tb.sv
